/* hw/rtl/murmur64a_hash_fold_top_assert.svh */
// ----------------------------------------------------------------------------
// murmur64a_hash_fold_top_assert.svh
// Assertion macros shared by the hash fold RTL. They expand to nothing under
// synthesis.
// ----------------------------------------------------------------------------
`ifndef MURMUR64A_HASH_FOLD_TOP_ASSERT_SVH
`define MURMUR64A_HASH_FOLD_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define MH_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("%m: check failed");
`define MH_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("%m: check failed");
`define MH_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("%m: check failed");
`else
`define MH_ASSERT(lbl, clk, rstn, prop)
`define MH_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define MH_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

/* hw/rtl/mh64f_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mh64f_pkg
// Shared constants and types of the MurmurHash64A fold block.
// ----------------------------------------------------------------------------
package mh64f_pkg;

  localparam logic [63:0] MIX_MUL   = 64'hc6a4a7935bd1e995;
  localparam logic [31:0] MIX_MUL_LO = MIX_MUL[31:0];
  localparam logic [31:0] MIX_MUL_HI = MIX_MUL[63:32];
  localparam int unsigned MIX_SHIFT = 47;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = QPTR_W + 1;

  localparam logic CFG_SEED      = 1'b0;
  localparam logic CFG_HASH_BITS = 1'b1;

  typedef struct packed {
    logic        first;
    logic        last;
    logic        full;
    logic        tail;
    logic        force_odd;
    logic [63:0] word;
    logic [31:0] key_length;
  } entry_t;

  typedef struct packed {
    logic        vld;
    logic [63:0] a;
  } mul_req_t;

  typedef struct packed {
    logic        vld;
    logic [63:0] p;
  } mul_rsp_t;

endpackage

/* hw/rtl/murmur64a_hash_fold_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// murmur64a_hash_fold_top
// MurmurHash64A over streamed 64-bit key words, xor-folded to hash_bits bits.
// ----------------------------------------------------------------------------
// One item is one key word; a word flagged tuser starts a key and seeds the
// hash from seed and key_length, a word flagged tlast finalizes it and yields
// one folded result. Items are held in a two-entry queue while a sequencer
// works through them on one shared two-stage 64-bit multiplier, so the time
// per word is set by its multiplies. A key start adds one multiply, a full
// word three, a tail word one, an empty word none; a last word adds one more
// multiply, then the xor fold and the load of the output register.
module murmur64a_hash_fold_top (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic         cfg_idx_i,
  input  logic [31:0]  cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // key_word[63:0], valid_bytes[67:64], key_length[99:68], force_odd[100]
  input  logic [103:0] s_axis_tdata,
  input  logic         s_axis_tlast,
  // first_word[0]
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // hash_value[62:0]
  output logic [63:0]  m_axis_tdata
);
  import mh64f_pkg::*;

  logic [31:0] seed_q;
  logic [5:0]  hash_bits_q;
  logic        push;
  entry_t      push_data;
  logic        q_full;
  logic        q_valid;
  entry_t      q_data;
  logic        q_pop;
  mul_req_t    mreq;
  mul_rsp_t    mrsp;
  logic [62:0] hash;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q      <= 32'd13;
      hash_bits_q <= 6'd16;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SEED:      seed_q      <= cfg_data_i;
        CFG_HASH_BITS: hash_bits_q <= cfg_data_i[5:0];
        default: begin
          seed_q <= seed_q;
        end
      endcase
    end
  end

  mh64f_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .q_full_i      (q_full),
    .push_o        (push),
    .push_data_o   (push_data)
  );

  mh64f_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .data_o      (q_data),
    .pop_i       (q_pop)
  );

  mh64f_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mreq),
    .rsp_o  (mrsp)
  );

  mh64f_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .seed_i      (seed_q),
    .hash_bits_i (hash_bits_q),
    .q_valid_i   (q_valid),
    .q_data_i    (q_data),
    .q_pop_o     (q_pop),
    .mreq_o      (mreq),
    .mrsp_i      (mrsp),
    .m_tvalid_o  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .hash_o      (hash)
  );

  assign m_axis_tdata = {1'b0, hash};

endmodule

/* hw/rtl/mh64f_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mh64f_front
// Accepts key words and classifies them as full, tail or empty words.
// ----------------------------------------------------------------------------
module mh64f_front (
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [103:0]      s_axis_tdata,
  input  logic              s_axis_tlast,
  input  logic              s_axis_tuser,
  input  logic              q_full_i,
  output logic              push_o,
  output mh64f_pkg::entry_t push_data_o
);
  import mh64f_pkg::*;

  logic [63:0] key_word;
  logic [3:0]  valid_bytes;
  logic [3:0]  nb;
  logic [63:0] byte_mask;

  assign key_word    = s_axis_tdata[63:0];
  assign valid_bytes = s_axis_tdata[67:64];
  assign nb          = (valid_bytes > 4'd8) ? 4'd8 : valid_bytes;

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      byte_mask[8*i +: 8] = (4'(i) < nb) ? 8'hff : 8'h00;
    end
  end

  assign s_axis_tready = !q_full_i;
  assign push_o        = s_axis_tvalid && !q_full_i;

  always_comb begin
    push_data_o.first      = s_axis_tuser;
    push_data_o.last       = s_axis_tlast;
    push_data_o.full       = (nb == 4'd8);
    push_data_o.tail       = (nb != 4'd8) && (nb != 4'd0);
    push_data_o.force_odd  = s_axis_tdata[100];
    push_data_o.word       = key_word & byte_mask;
    push_data_o.key_length = s_axis_tdata[99:68];
  end

endmodule

/* hw/rtl/mh64f_queue.sv */
`timescale 1ns / 1ps
`include "murmur64a_hash_fold_top_assert.svh"
// ----------------------------------------------------------------------------
// mh64f_queue
// Short FIFO of classified items between the front and the back.
// ----------------------------------------------------------------------------
module mh64f_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  mh64f_pkg::entry_t push_data_i,
  output logic              full_o,
  output logic              valid_o,
  output mh64f_pkg::entry_t data_o,
  input  logic              pop_i
);
  import mh64f_pkg::*;

  entry_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q + QCNT_W'(push_i) - QCNT_W'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  `MH_ASSERT(a_cnt_bound, clk_i, rst_ni, cnt_q <= QCNT_W'(QDEPTH))
  `MH_ASSERT_IMP(a_pop_nonempty, clk_i, rst_ni, pop_i, cnt_q != '0)
  `MH_ASSERT_IMP(a_push_room, clk_i, rst_ni, push_i, cnt_q != QCNT_W'(QDEPTH))

endmodule

/* hw/rtl/mh64f_mul.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mh64f_mul
// Two-stage 64-bit multiply by the mixing constant, low 64 bits kept.
// ----------------------------------------------------------------------------
module mh64f_mul (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mh64f_pkg::mul_req_t req_i,
  output mh64f_pkg::mul_rsp_t rsp_o
);
  import mh64f_pkg::*;

  logic [63:0] pp0;
  logic [31:0] pp1;
  logic [31:0] pp2;
  logic [63:0] pp0_q;
  logic [31:0] pp1_q;
  logic [31:0] pp2_q;
  logic [63:0] p_q;
  logic        v1_q;
  logic        v2_q;

  assign pp0 = {32'd0, req_i.a[31:0]} * {32'd0, MIX_MUL_LO};
  assign pp1 = req_i.a[31:0]  * MIX_MUL_HI;
  assign pp2 = req_i.a[63:32] * MIX_MUL_LO;

  always_ff @(posedge clk_i) begin
    pp0_q <= pp0;
    pp1_q <= pp1;
    pp2_q <= pp2;
    p_q   <= pp0_q + {pp1_q + pp2_q, 32'd0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= req_i.vld;
      v2_q <= v1_q;
    end
  end

  assign rsp_o.vld = v2_q;
  assign rsp_o.p   = p_q;

endmodule

/* hw/rtl/mh64f_back.sv */
`timescale 1ns / 1ps
`include "murmur64a_hash_fold_top_assert.svh"
// ----------------------------------------------------------------------------
// mh64f_back
// Sequences seeding, word mixing, finalization and folding of each item.
// ----------------------------------------------------------------------------
module mh64f_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [31:0]         seed_i,
  input  logic [5:0]          hash_bits_i,
  input  logic                q_valid_i,
  input  mh64f_pkg::entry_t   q_data_i,
  output logic                q_pop_o,
  output mh64f_pkg::mul_req_t mreq_o,
  input  mh64f_pkg::mul_rsp_t mrsp_i,
  output logic                m_tvalid_o,
  input  logic                m_tready_i,
  output logic [62:0]         hash_o
);
  import mh64f_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SEED = 4'd1;
  localparam logic [3:0] S_BODY = 4'd2;
  localparam logic [3:0] S_KA   = 4'd3;
  localparam logic [3:0] S_KB   = 4'd4;
  localparam logic [3:0] S_HM   = 4'd5;
  localparam logic [3:0] S_LAST = 4'd6;
  localparam logic [3:0] S_FM   = 4'd7;
  localparam logic [3:0] S_FOLD = 4'd8;
  localparam logic [3:0] S_EMIT = 4'd9;

  logic [3:0]   st_q, st_d;
  entry_t       op_q, op_d;
  logic [63:0]  h_q, h_d;
  logic [63:0]  j_q, j_d;
  logic [6:0]   sh_q, sh_d;
  logic         ovld_q, ovld_d;
  logic [62:0]  odata_q, odata_d;
  logic [63:0]  p_mix;
  logic [63:0]  h_asr;
  logic [62:0]  res_mask;
  logic         emit_fire;

  assign p_mix    = mrsp_i.p ^ (mrsp_i.p >> MIX_SHIFT);
  assign h_asr    = $unsigned($signed(h_q) >>> sh_q[5:0]);
  assign res_mask = ~({63{1'b1}} << hash_bits_i);
  assign emit_fire = (st_q == S_EMIT) && (!ovld_q || m_tready_i);

  always_comb begin
    st_d       = st_q;
    op_d       = op_q;
    h_d        = h_q;
    j_d        = j_q;
    sh_d       = sh_q;
    ovld_d     = ovld_q && !m_tready_i;
    odata_d    = odata_q;
    q_pop_o    = 1'b0;
    mreq_o.vld = 1'b0;
    mreq_o.a   = '0;
    case (st_q)
      S_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          op_d    = q_data_i;
          if (q_data_i.first) begin
            mreq_o.vld = 1'b1;
            mreq_o.a   = {32'd0, q_data_i.key_length};
            st_d       = S_SEED;
          end else begin
            st_d = S_BODY;
          end
        end
      end
      S_SEED: begin
        if (mrsp_i.vld) begin
          h_d  = {32'd0, seed_i} ^ mrsp_i.p;
          st_d = S_BODY;
        end
      end
      S_BODY: begin
        if (op_q.full) begin
          mreq_o.vld = 1'b1;
          mreq_o.a   = op_q.word;
          st_d       = S_KA;
        end else if (op_q.tail) begin
          mreq_o.vld = 1'b1;
          mreq_o.a   = h_q ^ op_q.word;
          st_d       = S_HM;
        end else begin
          st_d = S_LAST;
        end
      end
      S_KA: begin
        if (mrsp_i.vld) begin
          mreq_o.vld = 1'b1;
          mreq_o.a   = p_mix;
          st_d       = S_KB;
        end
      end
      S_KB: begin
        if (mrsp_i.vld) begin
          mreq_o.vld = 1'b1;
          mreq_o.a   = h_q ^ mrsp_i.p;
          st_d       = S_HM;
        end
      end
      S_HM: begin
        if (mrsp_i.vld) begin
          h_d  = mrsp_i.p;
          st_d = S_LAST;
        end
      end
      S_LAST: begin
        if (op_q.last) begin
          mreq_o.vld = 1'b1;
          mreq_o.a   = h_q ^ (h_q >> MIX_SHIFT);
          st_d       = S_FM;
        end else begin
          st_d = S_IDLE;
        end
      end
      S_FM: begin
        if (mrsp_i.vld) begin
          h_d  = p_mix;
          j_d  = (hash_bits_i == 6'd0) ? 64'd0 : p_mix;
          sh_d = {1'b0, hash_bits_i};
          st_d = S_FOLD;
        end
      end
      S_FOLD: begin
        if (sh_q[6] || (hash_bits_i == 6'd0)) begin
          st_d = S_EMIT;
        end else begin
          j_d  = j_q ^ h_asr;
          sh_d = sh_q + {1'b0, hash_bits_i};
        end
      end
      S_EMIT: begin
        if (emit_fire) begin
          ovld_d  = 1'b1;
          odata_d = (j_q[62:0] & res_mask) | {62'd0, op_q.force_odd};
          st_d    = S_IDLE;
        end
      end
      default: begin
        st_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    j_q     <= j_d;
    sh_q    <= sh_d;
    odata_q <= odata_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= S_IDLE;
      h_q    <= '0;
      ovld_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      h_q    <= h_d;
      ovld_q <= ovld_d;
    end
  end

  assign m_tvalid_o = ovld_q;
  assign hash_o     = odata_q;

  `MH_ASSERT_IMP(a_rsp_in_wait, clk_i, rst_ni, mrsp_i.vld,
                 st_q == S_SEED || st_q == S_KA || st_q == S_KB || st_q == S_HM || st_q == S_FM)
  `MH_ASSERT_NXT(a_one_in_flight, clk_i, rst_ni, mreq_o.vld, !mrsp_i.vld)
  `MH_ASSERT_NXT(a_emit_lands, clk_i, rst_ni, emit_fire, m_tvalid_o && st_q == S_IDLE)

endmodule

/* tb/tb_murmur64a_hash_fold_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_murmur64a_hash_fold_top
// Self-checking bench for the streamed MurmurHash64A fold block.
// ----------------------------------------------------------------------------
// Key words go in on the slave stream and folded hashes come back on the
// master stream. A short table of directed words covers the corner cases of
// the word flags, byte counts and fold widths; random keys, mostly well-formed
// with some malformed noise, follow under several seed and width settings and
// several idle and stall patterns. A local hash model predicts the results, typed
// table rows giving their own, and each one that comes back is checked in order.
module tb_murmur64a_hash_fold_top;
  import mh64f_pkg::*;

  localparam logic [63:0] MURMUR_M   = 64'hc6a4a7935bd1e995;
  localparam int unsigned MURMUR_R   = 47;
  localparam int unsigned IDLE_GAP   = 200;
  localparam int unsigned CYC_LIMIT  = 1000000;
  localparam int unsigned PHASE_KEYS = 190;

  typedef struct packed {
    logic        first;
    logic        last;
    logic [63:0] word;
    logic [3:0]  nb;
    logic [31:0] klen;
    logic        odd;
  } key_item_t;

  typedef struct packed {
    logic        first;
    logic        last;
    logic [63:0] word;
    logic [3:0]  nb;
    logic [31:0] klen;
    logic        odd;
    logic [5:0]  new_bits;
    logic        typed;
    logic        t_has;
    logic [63:0] tval;
  } dir_row_t;

  localparam int unsigned DIR_ROWS = 20;
  localparam dir_row_t DIR_TAB [DIR_ROWS] = '{
    '{1'b0, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8,  32'd0,       1'b0, 6'd0,  1'b1, 1'b0, 64'd0},
    '{1'b1, 1'b1, 64'h0,                   4'd0,  32'd0,       1'b0, 6'd0,  1'b0, 1'b0, 64'd0},
    '{1'b1, 1'b0, 64'h0,                   4'd8,  32'd16,      1'b0, 6'd0,  1'b1, 1'b0, 64'd0},
    '{1'b0, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8,  32'd0,       1'b0, 6'd0,  1'b0, 1'b0, 64'd0},
    '{1'b1, 1'b1, 64'h8000_0000_0000_0001, 4'd8,  32'hFFFFFFFF, 1'b1, 6'd0, 1'b0, 1'b0, 64'd0},
    '{1'b1, 1'b0, 64'h0123_4567_89AB_CDEF, 4'd3,  32'd11,      1'b0, 6'd0,  1'b1, 1'b0, 64'd0},
    '{1'b0, 1'b1, 64'hFEDC_BA98_7654_3210, 4'd8,  32'd0,       1'b1, 6'd0,  1'b0, 1'b0, 64'd0},
    '{1'b1, 1'b0, 64'h5A5A_5A5A_A5A5_A5A5, 4'd15, 32'd9,       1'b0, 6'd0,  1'b1, 1'b0, 64'd0},
    '{1'b0, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 4'd1,  32'd0,       1'b0, 6'd0,  1'b0, 1'b0, 64'd0},
    '{1'b1, 1'b0, 64'h0000_0000_FFFF_FFFF, 4'd8,  32'd100,     1'b0, 6'd0,  1'b1, 1'b0, 64'd0},
    '{1'b0, 1'b1, 64'h1234_5678_9ABC_DEF0, 4'd0,  32'd0,       1'b1, 6'd0,  1'b0, 1'b0, 64'd0},
    '{1'b0, 1'b1, 64'h0F0F_0F0F_0F0F_0F0F, 4'd7,  32'd0,       1'b0, 6'd0,  1'b0, 1'b0, 64'd0},
    '{1'b1, 1'b1, 64'hDEAD_BEEF_CAFE_F00D, 4'd9,  32'd8,       1'b1, 6'd0,  1'b0, 1'b0, 64'd0},
    '{1'b0, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0,  32'd0,       1'b0, 6'd0,  1'b1, 1'b0, 64'd0},
    '{1'b1, 1'b1, 64'hAABB_CCDD_1122_3344, 4'd4,  32'd4,       1'b0, 6'd0,  1'b0, 1'b0, 64'd0},
    '{1'b1, 1'b1, 64'h7777_8888_9999_AAAA, 4'd8,  32'd8,       1'b1, 6'd1,  1'b1, 1'b1, 64'd1},
    '{1'b1, 1'b1, 64'h0000_00FF_EEDD_CCBB, 4'd5,  32'd5,       1'b0, 6'd0,  1'b0, 1'b0, 64'd0},
    '{1'b1, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8,  32'hFFFFFFFF, 1'b1, 6'd63, 1'b0, 1'b0, 64'd0},
    '{1'b1, 1'b0, 64'h8000_0000_0000_0000, 4'd8,  32'd10,      1'b0, 6'd0,  1'b1, 1'b0, 64'd0},
    '{1'b0, 1'b1, 64'h0000_0000_0000_BEEF, 4'd2,  32'd0,       1'b0, 6'd0,  1'b0, 1'b0, 64'd0}
  };

  logic          clk_i;
  logic          rst_ni;
  logic          cfg_we_i;
  logic          cfg_idx_i;
  logic [31:0]   cfg_data_i;
  logic          s_axis_tvalid;
  logic          s_axis_tready;
  logic [103:0]  s_axis_tdata;
  logic          s_axis_tlast;
  logic          s_axis_tuser;
  logic          m_axis_tvalid;
  logic          m_axis_tready;
  logic [63:0]   m_axis_tdata;

  logic [31:0]   cur_seed;
  logic [5:0]    cur_bits;
  logic [63:0]   run_hash;
  logic [63:0]   hash_exp_q[$];
  logic [63:0]   hash_want;
  int unsigned   mismatch_cnt;
  int unsigned   cyc_cnt;
  int unsigned   src_idle_pct;
  int unsigned   snk_stall_pct;

  murmur64a_hash_fold_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  function automatic logic [63:0] xor_fold(input logic [63:0] x, input int unsigned b);
    logic [63:0] acc;
    logic [63:0] part;
    acc = x;
    if (b == 0) return '0;
    for (int unsigned s = b; s < 64; s += b) begin
      part = $signed(x) >>> s;
      acc ^= part;
    end
    return acc & ((64'd1 << b) - 64'd1);
  endfunction

  // advance the running hash by one word; returns 1 when a hash comes out
  function automatic bit murmur_word_step(input key_item_t it, output logic [63:0] folded);
    logic [63:0] h;
    logic [63:0] k;
    logic [3:0]  nb;
    folded = '0;
    h = it.first ? ({32'd0, cur_seed} ^ (64'(it.klen) * MURMUR_M)) : run_hash;
    nb = (it.nb > 4'd8) ? 4'd8 : it.nb;
    if (nb == 4'd8) begin
      k = it.word * MURMUR_M;
      k ^= k >> MURMUR_R;
      k = k * MURMUR_M;
      h ^= k;
      h = h * MURMUR_M;
    end else if (nb != 4'd0) begin
      h ^= it.word & ((64'd1 << {nb, 3'b000}) - 64'd1);
      h = h * MURMUR_M;
    end
    if (!it.last) begin
      run_hash = h;
      return 1'b0;
    end
    h ^= h >> MURMUR_R;
    h = h * MURMUR_M;
    h ^= h >> MURMUR_R;
    run_hash = h;
    folded = xor_fold(h, 32'(cur_bits));
    if (it.odd) folded[0] = 1'b1;
    folded[63] = 1'b0;
    return 1'b1;
  endfunction

  // entered and left at a falling edge
  task automatic send_word(input key_item_t it, input bit typed, input bit t_has,
                           input logic [63:0] tval);
    logic [63:0] folded;
    bit          has;
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, it.odd, it.klen, it.nb, it.word};
    s_axis_tlast  <= it.last;
    s_axis_tuser  <= it.first;
    do @(posedge clk_i); while (!s_axis_tready);
    has = murmur_word_step(it, folded);
    if (typed) begin
      if (t_has) hash_exp_q.push_back(tval);
    end else if (has) begin
      hash_exp_q.push_back(folded);
    end
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (hash_exp_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic settle();
    wait_drained();
    repeat (IDLE_GAP) @(negedge clk_i);
  endtask

  task automatic write_hash_cfg(input logic [31:0] seed, input logic [5:0] bits);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_SEED;
    cfg_data_i <= seed;
    @(negedge clk_i);
    cfg_idx_i  <= CFG_HASH_BITS;
    cfg_data_i <= {26'd0, bits};
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    cur_seed = seed;
    cur_bits = bits;
  endtask

  task automatic send_key(inout int unsigned cnt);
    key_item_t   it;
    int unsigned len;
    int unsigned nw;
    int unsigned r;
    r = $urandom_range(99);
    if (r < 85) begin
      len = ($urandom_range(99) < 70) ? $urandom_range(40) : $urandom_range(200, 41);
      nw = (len == 0) ? 1 : (len + 7) / 8;
      for (int unsigned i = 0; i < nw; i++) begin
        it.first = (i == 0);
        it.last  = (i == nw - 1);
        it.word  = {$urandom, $urandom};
        it.nb    = it.last ? 4'(len - 8 * i) : 4'd8;
        it.klen  = $urandom;
        if (it.first && $urandom_range(19) != 0) it.klen = len;
        it.odd   = 1'($urandom_range(1));
        send_word(it, 1'b0, 1'b0, '0);
        cnt++;
      end
    end else begin
      nw = $urandom_range(3, 1);
      for (int unsigned i = 0; i < nw; i++) begin
        it.first = 1'($urandom_range(1));
        it.last  = 1'($urandom_range(1));
        it.word  = {$urandom, $urandom};
        it.nb    = 4'($urandom_range(15));
        it.klen  = $urandom;
        it.odd   = 1'($urandom_range(1));
        send_word(it, 1'b0, 1'b0, '0);
        cnt++;
      end
    end
  endtask

  always @(negedge clk_i) begin
    if (rst_ni) m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (hash_exp_q.size() == 0) begin
        $display("%0t: unexpected hash, expected none actual %h", $time, m_axis_tdata);
        mismatch_cnt++;
      end else begin
        hash_want = hash_exp_q.pop_front();
        if (m_axis_tdata !== hash_want) begin
          $display("%0t: hash mismatch, expected %h actual %h", $time, hash_want,
                   m_axis_tdata);
          mismatch_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cyc_cnt++;
    if (cyc_cnt == CYC_LIMIT) begin
      $display("%0t: timeout", $time);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    key_item_t   it;
    dir_row_t    row;
    int unsigned sent;
    bit          paused;
    logic [31:0] ph_seed [5];
    logic [5:0]  ph_bits [5];
    int unsigned ph_src  [5];
    int unsigned ph_snk  [5];
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_SEED;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    s_axis_tuser  = 1'b0;
    m_axis_tready = 1'b0;
    mismatch_cnt  = 0;
    cyc_cnt       = 0;
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    cur_seed      = 32'd13;
    cur_bits      = 6'd16;
    run_hash      = '0;
    ph_seed = '{32'hFFFFFFFF, 32'h0, $urandom, 32'h80000000, $urandom};
    ph_bits = '{6'd63, 6'd1, 6'($urandom_range(63, 1)), 6'd32, 6'($urandom_range(63, 1))};
    ph_src  = '{0, 83, 0, 29, 0};
    ph_snk  = '{0, 0, 83, 29, 0};
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int unsigned i = 0; i < DIR_ROWS; i++) begin
      row = DIR_TAB[i];
      if (row.new_bits != 6'd0) begin
        settle();
        write_hash_cfg(cur_seed, row.new_bits);
      end
      it = '{row.first, row.last, row.word, row.nb, row.klen, row.odd};
      send_word(it, row.typed, row.t_has, row.tval);
    end

    for (int ph = 0; ph < 5; ph++) begin
      settle();
      write_hash_cfg(ph_seed[ph], ph_bits[ph]);
      src_idle_pct  = ph_src[ph];
      snk_stall_pct = ph_snk[ph];
      sent   = 0;
      paused = 1'b0;
      while (sent < PHASE_KEYS) begin
        send_key(sent);
        if (ph == 3 && !paused && sent >= PHASE_KEYS / 2) begin
          wait_drained();
          paused = 1'b1;
        end
      end
    end

    settle();
    if (mismatch_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
